FILE: rtl/tcrs_pkg.sv
// Shared types, widths and constants of the trail smoother.
package tcrs_pkg;

	localparam int COORD_W = 32;
	localparam int STAMP_W = 64;
	localparam int THR_W   = 31;
	localparam int SQ_W    = 2 * THR_W;
	localparam int SEG_W   = 3;
	localparam int WGT_W   = 9;
	localparam int TDATA_W = 3 * COORD_W + STAMP_W;
	localparam int TUSER_W = 3;
	localparam int MAX_RES = 6;
	localparam int RES_W   = 3;
	localparam int WIN_N   = 4;

	// Square of the reset threshold of 10.0 in Q23.8 (2560 * 2560).
	localparam logic [SQ_W-1:0] THR_SQ_RST = SQ_W'(64'd6553600);

	localparam logic [SEG_W-1:0] SEG_FULL = 3'd4;

	typedef enum logic [1:0] {
		KIND_TRAIL    = 2'd0,
		KIND_TP_START = 2'd1,
		KIND_TP_END   = 2'd2
	} kind_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
		logic [STAMP_W-1:0]        stamp;
	} pt_t;

	// One result to be produced: a curve point at phase sel, or the raw point in slot sel.
	typedef struct packed {
		logic       curve;
		logic [1:0] sel;
		kind_t      kind;
		logic       done;
	} op_t;

	// Uniform Catmull-Rom weights over 128 for t = 0, 1/4, 1/2 and 3/4.
	localparam logic signed [WGT_W-1:0] CR_W [WIN_N][WIN_N] = '{
		'{9'sd0,  9'sd128, 9'sd0,   9'sd0},
		'{-9'sd9, 9'sd111, 9'sd29,  -9'sd3},
		'{-9'sd8, 9'sd72,  9'sd72,  -9'sd8},
		'{-9'sd3, 9'sd29,  9'sd111, -9'sd9}
	};

endpackage

FILE: rtl/tcrs_blend.sv
// One axis of a Catmull-Rom point: weighted sum of four taps, floored and saturated.
module tcrs_blend import tcrs_pkg::*; (
	input  logic signed [COORD_W-1:0] p0,
	input  logic signed [COORD_W-1:0] p1,
	input  logic signed [COORD_W-1:0] p2,
	input  logic signed [COORD_W-1:0] p3,
	input  logic [1:0]                phase,
	output logic signed [COORD_W-1:0] res
);

	localparam int ACC_W = COORD_W + WGT_W;
	localparam int Q_W   = ACC_W - 7;

	logic signed [ACC_W-1:0] t0, t1, t2, t3, acc;
	logic signed [Q_W-1:0]   q;
	logic                    in_range;

	assign t0  = ACC_W'(CR_W[phase][0]) * ACC_W'(p0);
	assign t1  = ACC_W'(CR_W[phase][1]) * ACC_W'(p1);
	assign t2  = ACC_W'(CR_W[phase][2]) * ACC_W'(p2);
	assign t3  = ACC_W'(CR_W[phase][3]) * ACC_W'(p3);
	assign acc = (t0 + t1) + (t2 + t3);

	// An arithmetic shift by seven is the floor of the division by 128.
	assign q = signed'(acc[ACC_W-1:7]);

	assign in_range = (q[Q_W-1:COORD_W-1] == '0) || (q[Q_W-1:COORD_W-1] == '1);

	always_comb begin
		if (in_range) begin
			res = q[COORD_W-1:0];
		end else if (q[Q_W-1]) begin
			res = {1'b1, {(COORD_W-1){1'b0}}};
		end else begin
			res = {1'b0, {(COORD_W-1){1'b1}}};
		end
	end

endmodule

FILE: rtl/trail_split_catmull_rom_smoother.sv
// Top level of the trail smoother: split detection, segment control and result sequencing.
//
// Channel   Dir  Handshake                      Content
// s_axis    in   s_axis_tvalid/s_axis_tready    one trail point; tlast marks the end of history
// m_axis    out  m_axis_tvalid/m_axis_tready    one trail point or teleport record
// cfg       in   cfg_we (no back-pressure)      teleport threshold, Q23.8
//
// A point passes an input register, a register holding the squared step lengths and a run
// register before its first result reaches the output register. The run register hands over
// one result per cycle while the output is not stalled; a point causes at most six results and
// may cause none. The input side takes a new point while the input register is empty or can
// pass its point on; the run register is free again in the cycle that the last result of the
// previous run moves on. Stalls on the output hold the output register and back up through the
// run register to the input. Reset clears the pipeline valids, the open segment and sets the
// threshold to 10.0; the history registers are not cleared, as they are read only once written.
module trail_split_catmull_rom_smoother import tcrs_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	// pos_x [31:0], pos_y [63:32], pos_z [95:64], stamp [159:96]
	input  logic [TDATA_W-1:0] s_axis_tdata,
	input  logic               s_axis_tlast,
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	// out_x [31:0], out_y [63:32], out_z [95:64], out_stamp [159:96]
	output logic [TDATA_W-1:0] m_axis_tdata,
	output logic               m_axis_tlast,
	// kind [1:0], segment_done [2]
	output logic [TUSER_W-1:0] m_axis_tuser,
	input  logic               cfg_we,
	input  logic [THR_W-1:0]   cfg_wdata
);

	// Slots of the four-point window held by a run: oldest history point first, new point last.
	localparam logic [1:0] P0 = 2'd0;
	localparam logic [1:0] P1 = 2'd1;
	localparam logic [1:0] P2 = 2'd2;
	localparam logic [1:0] P3 = 2'd3;

	function automatic logic [COORD_W-1:0] abs_diff(
		input logic signed [COORD_W-1:0] a,
		input logic signed [COORD_W-1:0] b
	);
		logic signed [COORD_W:0] d;
		d = (COORD_W+1)'(a) - (COORD_W+1)'(b);
		return d[COORD_W] ? COORD_W'(-d) : d[COORD_W-1:0];
	endfunction

	function automatic op_t mk_op(input logic curve, input logic [1:0] sel, input kind_t kind,
		input logic done);
		op_t o;
		o.curve = curve;
		o.sel   = sel;
		o.kind  = kind;
		o.done  = done;
		return o;
	endfunction

	// Configuration: the threshold is only ever compared squared, so the square is kept.
	logic [SQ_W-1:0] thr_sq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_sq_q <= THR_SQ_RST;
		end else if (cfg_we) begin
			thr_sq_q <= SQ_W'(cfg_wdata) * SQ_W'(cfg_wdata);
		end
	end

	// Handshake and flow control along the pipe.
	logic s_acc, s1_rdy, s2_rdy, s1_adv, s2_adv;
	logic v_s1, v_s2;
	logic run_v_q, run_free, run_done, out_ld;
	logic m_valid_q;

	// Every transfer is pushed into the history, so the window is simply the last three inputs.
	pt_t in_pt;
	pt_t h0_q, h1_q, h2_q;

	assign in_pt.x     = s_axis_tdata[COORD_W-1:0];
	assign in_pt.y     = s_axis_tdata[2*COORD_W-1:COORD_W];
	assign in_pt.z     = s_axis_tdata[3*COORD_W-1:2*COORD_W];
	assign in_pt.stamp = s_axis_tdata[TDATA_W-1:3*COORD_W];

	assign s2_rdy        = !v_s2 || run_free;
	assign s1_rdy        = !v_s1 || s2_rdy;
	assign s_axis_tready = s1_rdy;
	assign s_acc         = s_axis_tvalid && s1_rdy;
	assign s1_adv        = v_s1 && s2_rdy;
	assign s2_adv        = v_s2 && run_free;

	always_ff @(posedge clk) begin
		if (s_acc) begin
			h0_q <= h1_q;
			h1_q <= h2_q;
			h2_q <= in_pt;
		end
	end

	// Stage 1: the new point with its window, per-axis step lengths and the stamp span.
	pt_t                cur_s1, h0_s1, h1_s1, h2_s1;
	logic               last_s1;
	logic [COORD_W-1:0] ax_s1, ay_s1, az_s1;
	logic [STAMP_W-1:0] dst_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_acc) begin
			v_s1 <= 1'b1;
		end else if (s1_adv) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			cur_s1  <= in_pt;
			h0_s1   <= h0_q;
			h1_s1   <= h1_q;
			h2_s1   <= h2_q;
			last_s1 <= s_axis_tlast;
			ax_s1   <= abs_diff(in_pt.x, h2_q.x);
			ay_s1   <= abs_diff(in_pt.y, h2_q.y);
			az_s1   <= abs_diff(in_pt.z, h2_q.z);
			dst_s1  <= in_pt.stamp - h0_q.stamp;
		end
	end

	// Stage 2: squared step lengths and the stamp offsets for a quarter, a half and three
	// quarters of the span. Any step of 2^31 or more splits whatever the threshold.
	pt_t                cur_s2, h0_s2, h1_s2, h2_s2;
	logic               last_s2, big_s2;
	logic [SQ_W-1:0]    sqx_s2, sqy_s2, sqz_s2;
	logic [STAMP_W-1:0] off1_s2, off2_s2, off3_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (s1_adv) begin
			v_s2 <= 1'b1;
		end else if (s2_adv) begin
			v_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			cur_s2  <= cur_s1;
			h0_s2   <= h0_s1;
			h1_s2   <= h1_s1;
			h2_s2   <= h2_s1;
			last_s2 <= last_s1;
			big_s2  <= ax_s1[COORD_W-1] || ay_s1[COORD_W-1] || az_s1[COORD_W-1];
			sqx_s2  <= SQ_W'(ax_s1[THR_W-1:0]) * SQ_W'(ax_s1[THR_W-1:0]);
			sqy_s2  <= SQ_W'(ay_s1[THR_W-1:0]) * SQ_W'(ay_s1[THR_W-1:0]);
			sqz_s2  <= SQ_W'(az_s1[THR_W-1:0]) * SQ_W'(az_s1[THR_W-1:0]);
			off1_s2 <= dst_s1 >> 2;
			off2_s2 <= dst_s1 >> 1;
			// floor(3d/4) is d less the ceiling of d/4.
			off3_s2 <= dst_s1 - (dst_s1 >> 2) - STAMP_W'(dst_s1[1:0] != 2'b00);
		end
	end

	// Segment control: decide the split and lay out the results of this point.
	logic [SEG_W-1:0]   seg_cnt_q, seg_post, seg_nxt;
	logic [STAMP_W-1:0] sumsq;
	logic               split;
	op_t                dec_ops [MAX_RES];
	logic [RES_W-1:0]   dec_cnt;

	assign sumsq = STAMP_W'(sqx_s2) + STAMP_W'(sqy_s2) + STAMP_W'(sqz_s2);
	assign split = (seg_cnt_q != '0) && (big_s2 || sumsq > STAMP_W'(thr_sq_q));

	always_comb begin
		for (int i = 0; i < MAX_RES; i++) begin
			dec_ops[i] = '0;
		end
		dec_cnt  = '0;
		seg_post = seg_cnt_q;
		if (seg_cnt_q == '0) begin
			seg_post = 3'd1;
		end else if (split) begin
			// The closing segment's tail, then the jump from its newest point to the new one.
			if (seg_cnt_q == 3'd3) begin
				dec_ops[dec_cnt] = mk_op(1'b0, P0, KIND_TRAIL, 1'b0);
				dec_cnt = dec_cnt + 3'd1;
			end
			if (seg_cnt_q >= 3'd2) begin
				dec_ops[dec_cnt] = mk_op(1'b0, P1, KIND_TRAIL, 1'b0);
				dec_cnt = dec_cnt + 3'd1;
				dec_ops[dec_cnt] = mk_op(1'b0, P2, KIND_TRAIL, 1'b1);
				dec_cnt = dec_cnt + 3'd1;
			end
			dec_ops[dec_cnt] = mk_op(1'b0, P2, KIND_TP_START, 1'b0);
			dec_cnt = dec_cnt + 3'd1;
			dec_ops[dec_cnt] = mk_op(1'b0, P3, KIND_TP_END, 1'b0);
			dec_cnt = dec_cnt + 3'd1;
			seg_post = 3'd1;
		end else begin
			if (seg_cnt_q >= 3'd3) begin
				for (int j = 0; j < WIN_N; j++) begin
					dec_ops[dec_cnt] = mk_op(1'b1, 2'(j), KIND_TRAIL, 1'b0);
					dec_cnt = dec_cnt + 3'd1;
				end
			end
			seg_post = (seg_cnt_q >= SEG_FULL) ? SEG_FULL : seg_cnt_q + 3'd1;
		end
		seg_nxt = seg_post;
		// End of history: the segment now open closes with the new point as its newest.
		if (last_s2) begin
			if (seg_post == 3'd3) begin
				dec_ops[dec_cnt] = mk_op(1'b0, P1, KIND_TRAIL, 1'b0);
				dec_cnt = dec_cnt + 3'd1;
			end
			if (seg_post >= 3'd2) begin
				dec_ops[dec_cnt] = mk_op(1'b0, P2, KIND_TRAIL, 1'b0);
				dec_cnt = dec_cnt + 3'd1;
				dec_ops[dec_cnt] = mk_op(1'b0, P3, KIND_TRAIL, 1'b1);
				dec_cnt = dec_cnt + 3'd1;
			end
			seg_nxt = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_cnt_q <= '0;
		end else if (s2_adv) begin
			seg_cnt_q <= seg_nxt;
		end
	end

	// Run register: one point's window and result list, one result per cycle unless stalled.
	logic [RES_W-1:0]   run_cnt_q, run_idx_q;
	op_t                run_ops_q [MAX_RES];
	pt_t                run_pt_q [WIN_N];
	logic [STAMP_W-1:0] run_off_q [WIN_N];
	logic               run_load, res_last;

	assign run_load = s2_adv && (dec_cnt != '0);
	assign out_ld   = run_v_q && (!m_valid_q || m_axis_tready);
	assign res_last = (run_idx_q == run_cnt_q - 3'd1);
	assign run_done = out_ld && res_last;
	assign run_free = !run_v_q || run_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_v_q   <= 1'b0;
			run_cnt_q <= '0;
			run_idx_q <= '0;
		end else if (run_load) begin
			run_v_q   <= 1'b1;
			run_cnt_q <= dec_cnt;
			run_idx_q <= '0;
		end else if (run_done) begin
			run_v_q   <= 1'b0;
		end else if (out_ld) begin
			run_idx_q <= run_idx_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (run_load) begin
			run_ops_q    <= dec_ops;
			run_pt_q[0]  <= h0_s2;
			run_pt_q[1]  <= h1_s2;
			run_pt_q[2]  <= h2_s2;
			run_pt_q[3]  <= cur_s2;
			run_off_q[0] <= '0;
			run_off_q[1] <= off1_s2;
			run_off_q[2] <= off2_s2;
			run_off_q[3] <= off3_s2;
		end
	end

	// Result generation for the current list entry.
	op_t                cur_op;
	pt_t                raw_pt;
	logic signed [COORD_W-1:0] bx, by, bz;
	logic [STAMP_W-1:0] curve_stamp;

	assign cur_op      = run_ops_q[run_idx_q];
	assign raw_pt      = run_pt_q[cur_op.sel];
	assign curve_stamp = run_pt_q[0].stamp + run_off_q[cur_op.sel];

	tcrs_blend u_blend_x (
		.p0    (run_pt_q[0].x),
		.p1    (run_pt_q[1].x),
		.p2    (run_pt_q[2].x),
		.p3    (run_pt_q[3].x),
		.phase (cur_op.sel),
		.res   (bx)
	);

	tcrs_blend u_blend_y (
		.p0    (run_pt_q[0].y),
		.p1    (run_pt_q[1].y),
		.p2    (run_pt_q[2].y),
		.p3    (run_pt_q[3].y),
		.phase (cur_op.sel),
		.res   (by)
	);

	tcrs_blend u_blend_z (
		.p0    (run_pt_q[0].z),
		.p1    (run_pt_q[1].z),
		.p2    (run_pt_q[2].z),
		.p3    (run_pt_q[3].z),
		.phase (cur_op.sel),
		.res   (bz)
	);

	// Output register: holds a result while the next one is prepared behind it.
	logic signed [COORD_W-1:0] o_x_q, o_y_q, o_z_q;
	logic [STAMP_W-1:0]        o_stamp_q;
	kind_t                     o_kind_q;
	logic                      o_done_q, o_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_ld) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ld) begin
			if (cur_op.curve) begin
				o_x_q     <= bx;
				o_y_q     <= by;
				o_z_q     <= bz;
				o_stamp_q <= curve_stamp;
			end else begin
				o_x_q     <= raw_pt.x;
				o_y_q     <= raw_pt.y;
				o_z_q     <= raw_pt.z;
				o_stamp_q <= raw_pt.stamp;
			end
			o_kind_q <= cur_op.kind;
			o_done_q <= cur_op.done;
			o_last_q <= res_last;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {o_stamp_q, o_z_q, o_y_q, o_x_q};
	assign m_axis_tlast  = o_last_q;
	assign m_axis_tuser  = {o_done_q, o_kind_q};

	// A live run always points inside its own result list.
	a_run_index: assert property (@(posedge clk) disable iff (!arst_n)
		run_v_q |-> (run_cnt_q != '0) && (run_idx_q < run_cnt_q))
		else $error("run index outside its result list");

	// The open segment count never passes four points.
	a_seg_bound: assert property (@(posedge clk) disable iff (!arst_n)
		seg_cnt_q <= SEG_FULL)
		else $error("segment count beyond four");

	// tlast on the output follows the final entry of the run that was handed over.
	a_run_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_ld |=> m_axis_tvalid && (m_axis_tlast == $past(res_last)))
		else $error("tlast does not match the end of the run");

	// A split always yields at least the teleport pair.
	a_split_pair: assert property (@(posedge clk) disable iff (!arst_n)
		(s2_adv && split) |-> (dec_cnt >= 3'd2))
		else $error("split without teleport pair");

	// Segment ends are marked on trail points only.
	a_done_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser[2]) |-> (m_axis_tuser[1:0] == KIND_TRAIL))
		else $error("segment end flagged on a teleport record");

endmodule
